/* sv/tao_pkg.sv */
// tao_pkg: shared types and status codes of the timed alarm output table.
// Used by tao_cell and by the top level timed_alarm_output_table_unit.
// Depends on nothing.
package tao_pkg;

    typedef logic [2:0] t_status;

    localparam t_status ST_TIME       = 3'd0;
    localparam t_status ST_STARTED    = 3'd1;
    localparam t_status ST_KEPT       = 3'd2;
    localparam t_status ST_CONFLICT   = 3'd3;
    localparam t_status ST_NOT_OUTPUT = 3'd4;

    // Request broadcast to every cell of the row.
    typedef struct packed {
        logic go;     // item accepted this cycle
        logic hit;    // this cell is the enabled target of an alarm request
        logic level;  // requested active level
    } t_req;

    // Post-item view of one channel, taken by the top level into the result beat.
    typedef struct packed {
        logic active;
        logic drv;
        logic expired;
    } t_cell_out;

endpackage

/* sv/tao_cell.sv */
// tao_cell: one channel of the alarm table (rule, countdown, pin level).
// Depends on tao_pkg; the status word ripples from the previous cell to the next.
module tao_cell #(
    parameter int TICK_BITS = 24
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tao_pkg::t_req      i_req,
    input  logic [TICK_BITS-1:0] i_hold,
    input  logic [TICK_BITS-1:0] i_elapsed,
    input  tao_pkg::t_status   i_status,
    output tao_pkg::t_status   o_status,
    output tao_pkg::t_cell_out o_next
);
    import tao_pkg::*;

    logic                 r_active, r_level, r_drv;
    logic [TICK_BITS-1:0] r_rem;
    logic                 n_active, n_level, n_drv;
    logic [TICK_BITS-1:0] n_rem;
    logic [TICK_BITS-1:0] w_aged;
    t_status              w_own;
    logic                 w_expire;

    always_comb begin
        // age the running rule, floor at zero
        if (r_active && (r_rem > i_elapsed)) begin
            w_aged = r_rem - i_elapsed;
        end else if (r_active) begin
            w_aged = '0;
        end else begin
            w_aged = r_rem;
        end

        n_active = r_active;
        n_level  = r_level;
        n_drv    = r_drv;
        n_rem    = w_aged;
        w_own    = ST_TIME;

        if (i_req.hit) begin
            if (r_active && (r_level != i_req.level)) begin
                w_own = ST_CONFLICT;
            end else if (r_active) begin
                w_own = ST_KEPT;
                if (i_hold > w_aged) begin
                    n_rem = i_hold;
                end
            end else begin
                w_own    = ST_STARTED;
                n_active = 1'b1;
                n_level  = i_req.level;
                n_rem    = i_hold;
                n_drv    = i_req.level;
            end
        end

        // drop rules that reached zero, pin to the inverse level
        w_expire = n_active && (n_rem == '0);
        if (w_expire) begin
            n_drv    = ~n_level;
            n_active = 1'b0;
        end
    end

    assign o_status       = i_status | w_own;
    assign o_next.active  = n_active;
    assign o_next.drv     = n_drv;
    assign o_next.expired = w_expire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_level  <= 1'b0;
            r_drv    <= 1'b0;
        end else if (i_req.go) begin
            r_active <= n_active;
            r_level  <= n_level;
            r_drv    <= n_drv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.go) begin
            r_rem <= n_rem;
        end
    end

endmodule

/* sv/timed_alarm_output_table_unit.sv */
// timed_alarm_output_table_unit: top level of the timed alarm output table.
// Holds the output enable register, the row of tao_cell and the result register.
// Depends on tao_pkg and tao_cell.
//
//  channel   | direction | handshake             | payload
//  ----------+-----------+-----------------------+-------------------------------------------
//  request   | in        | start && !busy        | i_command, i_channel, i_active_level,
//            |           |                       | i_hold_ticks, i_elapsed_ticks
//  result    | out       | o_strobe (one cycle)  | o_status, o_pin_levels, o_active_mask,
//            |           |                       | o_expired_mask
//  config    | in        | i_cfg_we              | i_cfg_wdata (output enable mask)
//
// Per beat, every cell ages, applies the request and expires its
// rule in the cycle the beat is accepted; the result beat shows on the next cycle.
// busy never rises, so a new beat may be taken in every cycle.
// Reset: synchronous, active low; clears all rules, pin levels and the enable mask.
// Stalls: the receiver cannot stall; each result beat is valid for one cycle only.
module timed_alarm_output_table_unit #(
    parameter int NUM_CHANNELS = 32,
    parameter int TICK_BITS    = 24
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_command,
    input  logic [4:0]  i_channel,
    input  logic        i_active_level,
    input  logic [23:0] i_hold_ticks,
    input  logic [23:0] i_elapsed_ticks,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    output logic        o_strobe,
    output logic [2:0]  o_status,
    output logic [31:0] o_pin_levels,
    output logic [31:0] o_active_mask,
    output logic [31:0] o_expired_mask
);
    import tao_pkg::*;

    logic [31:0]          r_oem;
    logic [TICK_BITS-1:0] w_hold, w_elapsed;
    logic                 w_accept;
    logic                 w_in_range, w_not_output;
    t_status              w_chain [0:NUM_CHANNELS];
    t_cell_out            w_next  [0:NUM_CHANNELS-1];
    logic [31:0]          w_pins, w_act, w_exp;
    t_status              w_status;

    // No wait state: one beat is done per cycle.
    assign busy     = 1'b0;
    assign w_accept = start && !busy;

    // Config write: taken whenever the enable is high.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oem <= '0;
        end else if (i_cfg_we) begin
            r_oem <= i_cfg_wdata;
        end
    end

    // Fit the 24-bit tick fields to the countdown width. Saturating elapsed is
    // safe: a countdown never exceeds the top of its range.
    generate
        if (TICK_BITS < 24) begin : g_sat
            assign w_hold    = (|i_hold_ticks[23:TICK_BITS]) ? '1
                                                              : i_hold_ticks[TICK_BITS-1:0];
            assign w_elapsed = (|i_elapsed_ticks[23:TICK_BITS]) ? '1
                                                                 : i_elapsed_ticks[TICK_BITS-1:0];
        end else begin : g_ext
            assign w_hold    = TICK_BITS'(i_hold_ticks);
            assign w_elapsed = TICK_BITS'(i_elapsed_ticks);
        end
    endgenerate

    // Refuse requests to channels beyond the bank or not enabled as outputs.
    assign w_in_range   = (32'(i_channel) < NUM_CHANNELS);
    assign w_not_output = i_command && !(w_in_range && r_oem[i_channel]);

    assign w_chain[0] = ST_TIME;

    generate
        for (genvar c = 0; c < NUM_CHANNELS; c++) begin : g_cell
            t_req w_req;
            logic w_en;
            if (c < 32) begin : g_en
                assign w_en = r_oem[c];
            end else begin : g_no_en
                assign w_en = 1'b0;
            end
            assign w_req.go    = w_accept;
            assign w_req.hit   = i_command && w_en && (32'(i_channel) == c);
            assign w_req.level = i_active_level;

            tao_cell #(
                .TICK_BITS (TICK_BITS)
            ) u_cell (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_req     (w_req),
                .i_hold    (w_hold),
                .i_elapsed (w_elapsed),
                .i_status  (w_chain[c]),
                .o_status  (w_chain[c+1]),
                .o_next    (w_next[c])
            );
        end

        // Gather masks; channels from 32 up are not reported, missing ones read zero.
        for (genvar b = 0; b < 32; b++) begin : g_mask
            if (b < NUM_CHANNELS) begin : g_have
                assign w_pins[b] = w_next[b].drv;
                assign w_act[b]  = w_next[b].active;
                assign w_exp[b]  = w_next[b].expired;
            end else begin : g_pad
                assign w_pins[b] = 1'b0;
                assign w_act[b]  = 1'b0;
                assign w_exp[b]  = 1'b0;
            end
        end
    endgenerate

    always_comb begin
        if (!i_command) begin
            w_status = ST_TIME;
        end else if (w_not_output) begin
            w_status = ST_NOT_OUTPUT;
        end else begin
            w_status = w_chain[NUM_CHANNELS];
        end
    end

    // Result strobe: rises in the cycle after each accepted beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= w_accept;
        end
    end

    // Hold the result payload from the accepting cycle.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            o_status       <= w_status;
            o_pin_levels   <= w_pins;
            o_active_mask  <= w_act;
            o_expired_mask <= w_exp;
        end
    end

    a_strobe_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_strobe)
        else $error("accepted beat gave no result strobe");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_accept |=> !o_strobe)
        else $error("result strobe without an accepted beat");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_status <= ST_NOT_OUTPUT))
        else $error("status code out of range");

    a_active_expired: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> ((o_active_mask & o_expired_mask) == 32'd0))
        else $error("channel both running and expired");

    a_time_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !i_command) |=> (o_status == ST_TIME))
        else $error("time-only beat reported a request status");

endmodule

/* dv/tao_alarm_checker.sv */
`timescale 1ns / 100ps
// tao_alarm_checker: models the timed alarm output table and compares its result beats.
// Depends on tao_pkg for the status codes; sits beside the DUT in the testbench top.
module tao_alarm_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_busy,
    input  logic        i_command,
    input  logic [4:0]  i_channel,
    input  logic        i_active_level,
    input  logic [23:0] i_hold_ticks,
    input  logic [23:0] i_elapsed_ticks,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    input  logic        i_strobe,
    input  logic [2:0]  i_status,
    input  logic [31:0] i_pin_levels,
    input  logic [31:0] i_active_mask,
    input  logic [31:0] i_expired_mask,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked
);
    import tao_pkg::*;

    typedef struct packed {
        t_status     status;
        logic [31:0] pins;
        logic [31:0] active;
        logic [31:0] expired;
    } t_alarm_result;

    // Shadow of the alarm table
    logic [31:0] enable_mask;
    logic [31:0] rule_on;
    logic [31:0] rule_lvl;
    logic [31:0] pin_level;
    logic [23:0] ticks_left [32];

    t_alarm_result due_results [$];
    t_alarm_result due;
    int            mismatches;
    int            results_checked;

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t: %s mismatch: expected 0x%08h, actual 0x%08h", $time, name, want, got);
        end
    endtask

    // Age every running rule, apply the request, then retire rules at zero.
    task automatic predict_alarm_item(input logic cmd, input logic [4:0] ch, input logic lvl,
                                      input logic [23:0] hold, input logic [23:0] elapsed,
                                      output t_alarm_result res);
        int c;
        res        = '0;
        res.status = ST_TIME;
        for (c = 0; c < 32; c++) begin
            if (rule_on[c])
                ticks_left[c] = (ticks_left[c] > elapsed) ? ticks_left[c] - elapsed : '0;
        end
        if (cmd) begin
            if (!enable_mask[ch]) begin
                res.status = ST_NOT_OUTPUT;
            end else if (rule_on[ch]) begin
                if (rule_lvl[ch] != lvl) begin
                    res.status = ST_CONFLICT;
                end else begin
                    if (hold > ticks_left[ch])
                        ticks_left[ch] = hold;
                    res.status = ST_KEPT;
                end
            end else begin
                rule_on[ch]    = 1'b1;
                rule_lvl[ch]   = lvl;
                ticks_left[ch] = hold;
                pin_level[ch]  = lvl;
                res.status     = ST_STARTED;
            end
        end
        for (c = 0; c < 32; c++) begin
            if (rule_on[c] && ticks_left[c] == '0) begin
                pin_level[c]   = ~rule_lvl[c];
                rule_on[c]     = 1'b0;
                res.expired[c] = 1'b1;
            end
        end
        res.pins   = pin_level;
        res.active = rule_on;
    endtask

    initial begin
        mismatches      = 0;
        results_checked = 0;
        o_fail_count    = 0;
        o_pending       = 0;
        o_checked       = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            enable_mask = '0;
            rule_on     = '0;
            rule_lvl    = '0;
            pin_level   = '0;
            for (int c = 0; c < 32; c++)
                ticks_left[c] = '0;
            due_results.delete();
        end else begin
            // Result beats leave in the cycle after their request, so retire first
            if (i_strobe) begin
                if (due_results.size() == 0) begin
                    mismatches++;
                    $display("%0t: result beat with none expected: status %0d", $time, i_status);
                end else begin
                    due = due_results.pop_front();
                    check_field("status", 32'(due.status), 32'(i_status));
                    check_field("pin_levels", due.pins, i_pin_levels);
                    check_field("active_mask", due.active, i_active_mask);
                    check_field("expired_mask", due.expired, i_expired_mask);
                    results_checked++;
                end
            end
            // A beat taken on the same edge as a mask write still sees the old mask
            if (i_start && !i_busy) begin
                predict_alarm_item(i_command, i_channel, i_active_level, i_hold_ticks,
                                   i_elapsed_ticks, due);
                due_results.push_back(due);
            end
            if (i_cfg_we)
                enable_mask = i_cfg_wdata;
        end
        o_fail_count <= mismatches;
        o_pending    <= due_results.size();
        o_checked    <= results_checked;
    end

endmodule

/* dv/tb_timed_alarm_output_table_unit.sv */
`timescale 1ns / 100ps
// tb_timed_alarm_output_table_unit: stimulus and verdict for timed_alarm_output_table_unit.
// Depends on tao_pkg, the DUT and tao_alarm_checker, which predicts and compares results.
module tb_timed_alarm_output_table_unit;

    import tao_pkg::*;

    localparam logic CMD_TIME  = 1'b0;
    localparam logic CMD_ALARM = 1'b1;

    localparam int PHASE_BEATS = 190;
    localparam int NUM_PHASES  = 5;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic        i_command;
    logic [4:0]  i_channel;
    logic        i_active_level;
    logic [23:0] i_hold_ticks;
    logic [23:0] i_elapsed_ticks;
    logic        i_cfg_we;
    logic [31:0] i_cfg_wdata;
    logic        o_strobe;
    logic [2:0]  o_status;
    logic [31:0] o_pin_levels;
    logic [31:0] o_active_mask;
    logic [31:0] o_expired_mask;

    int fail_count;
    int pending_results;
    int results_checked;

    // Bookkeeping for the closing summary
    int          beats_sent;
    int          alarm_beats;
    int          mask_settings;
    logic [31:0] cur_enable_mask;

    timed_alarm_output_table_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_command      (i_command),
        .i_channel      (i_channel),
        .i_active_level (i_active_level),
        .i_hold_ticks   (i_hold_ticks),
        .i_elapsed_ticks(i_elapsed_ticks),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_strobe       (o_strobe),
        .o_status       (o_status),
        .o_pin_levels   (o_pin_levels),
        .o_active_mask  (o_active_mask),
        .o_expired_mask (o_expired_mask)
    );

    tao_alarm_checker checker_i (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_command      (i_command),
        .i_channel      (i_channel),
        .i_active_level (i_active_level),
        .i_hold_ticks   (i_hold_ticks),
        .i_elapsed_ticks(i_elapsed_ticks),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_strobe       (o_strobe),
        .i_status       (o_status),
        .i_pin_levels   (o_pin_levels),
        .i_active_mask  (o_active_mask),
        .i_expired_mask (o_expired_mask),
        .o_fail_count   (fail_count),
        .o_pending      (pending_results),
        .o_checked      (results_checked)
    );

    // 10 ns clock
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Drive one request beat and hold it until the DUT takes it. Leave start high so
    // that back-to-back beats need no second assignment in the same step.
    task automatic send_beat(input logic cmd, input logic [4:0] ch, input logic lvl,
                             input logic [23:0] hold, input logic [23:0] elapsed);
        start           <= 1'b1;
        i_command       <= cmd;
        i_channel       <= ch;
        i_active_level  <= lvl;
        i_hold_ticks    <= hold;
        i_elapsed_ticks <= elapsed;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        beats_sent++;
        if (cmd == CMD_ALARM)
            alarm_beats++;
    endtask

    // Drop start for a burst of idle cycles.
    task automatic idle_for(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // Hold off until every predicted result has come back. The checker's count is
    // registered and trails the queue, so step past that register before trusting it.
    task automatic drain_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_results != 0)
            @(posedge i_clk);
    endtask

    // Reprogram the output enable mask; only legal with the table idle.
    task automatic write_enable_mask(input logic [31:0] value);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we        <= 1'b0;
        cur_enable_mask = value;
        mask_settings++;
    endtask

    // Random beat, mostly requests aimed at enabled channels with short holds and
    // short elapsed counts so rules overlap and get extended or contested.
    task automatic send_random_beat();
        logic        cmd;
        logic [4:0]  ch;
        logic [23:0] hold;
        logic [23:0] elapsed;
        cmd = ($urandom_range(0, 99) < 75) ? CMD_ALARM : CMD_TIME;
        ch  = $urandom_range(0, 1) ? 5'($urandom_range(0, 7)) : 5'($urandom_range(0, 31));
        if (cur_enable_mask != '0 && $urandom_range(0, 9) < 8) begin
            while (!cur_enable_mask[ch])
                ch = 5'($urandom_range(0, 31));
        end
        case ($urandom_range(0, 19))
            0:       hold = '0;
            1:       hold = 24'hFF_FFFF;
            2, 3:    hold = 24'($urandom);
            default: hold = 24'($urandom_range(1, 64));
        endcase
        case ($urandom_range(0, 19))
            0:          elapsed = 24'hFF_FFFF;
            1:          elapsed = 24'($urandom);
            2, 3, 4, 5: elapsed = '0;
            default:    elapsed = 24'($urandom_range(1, 16));
        endcase
        send_beat(cmd, ch, 1'($urandom_range(0, 1)), hold, elapsed);
    endtask

    // Give up well past the slowest legal run
    initial begin
        #2_000_000;
        $display("timed_alarm_output_table_unit test failed");
        $finish;
    end

    initial begin
        logic [31:0] phase_mask [NUM_PHASES];
        bit          allow_idle;

        start           = 1'b0;
        i_command       = CMD_TIME;
        i_channel       = '0;
        i_active_level  = 1'b0;
        i_hold_ticks    = '0;
        i_elapsed_ticks = '0;
        i_cfg_we        = 1'b0;
        i_cfg_wdata     = '0;
        i_rst_n         = 1'b0;
        beats_sent      = 0;
        alarm_beats     = 0;
        mask_settings   = 1;
        cur_enable_mask = '0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Enable mask still at its reset value: every request is refused
        send_beat(CMD_ALARM, 5'd5, 1'b1, 24'd5, 24'd0);
        send_beat(CMD_TIME, 5'd0, 1'b0, 24'd0, 24'd3);

        write_enable_mask(32'hFFFF_FFFF);
        // Time only beat with every ignored field at its top value
        send_beat(CMD_TIME, 5'd31, 1'b1, 24'hFF_FFFF, 24'd0);
        // Start, contest, extend and keep a rule on channel 0
        send_beat(CMD_ALARM, 5'd0, 1'b1, 24'd10, 24'd0);
        send_beat(CMD_ALARM, 5'd0, 1'b0, 24'd10, 24'd0);
        send_beat(CMD_ALARM, 5'd0, 1'b1, 24'd20, 24'd1);
        send_beat(CMD_ALARM, 5'd0, 1'b1, 24'd5, 24'd0);
        // Zero hold: start and expire in the same beat
        send_beat(CMD_ALARM, 5'd31, 1'b0, 24'd0, 24'd0);
        // Widest hold with the widest elapsed count
        send_beat(CMD_ALARM, 5'd16, 1'b1, 24'hFF_FFFF, 24'hFF_FFFF);
        // Rule aged to zero: a longer same-level hold extends it
        send_beat(CMD_ALARM, 5'd3, 1'b0, 24'd4, 24'd0);
        send_beat(CMD_ALARM, 5'd3, 1'b0, 24'd7, 24'd9);
        // Rule aged to zero: a zero hold keeps it and it expires
        send_beat(CMD_ALARM, 5'd4, 1'b1, 24'd2, 24'd0);
        send_beat(CMD_ALARM, 5'd4, 1'b1, 24'd0, 24'd5);
        // Rule aged to zero: an opposite level conflicts and the rule expires
        send_beat(CMD_ALARM, 5'd3, 1'b1, 24'd9, 24'd7);
        send_beat(CMD_TIME, 5'd0, 1'b0, 24'd0, 24'd20);
        send_beat(CMD_ALARM, 5'd16, 1'b0, 24'd1, 24'd0);
        send_beat(CMD_TIME, 5'd0, 1'b0, 24'd0, 24'hFF_FFFF);
        send_beat(CMD_ALARM, 5'd7, 1'b1, 24'd1, 24'd0);
        send_beat(CMD_ALARM, 5'd7, 1'b1, 24'd1, 24'd0);

        // Clear the mask again while a rule could still be pending elsewhere
        write_enable_mask(32'h0000_0000);
        send_beat(CMD_ALARM, 5'd9, 1'b1, 24'd5, 24'd0);
        send_beat(CMD_ALARM, 5'd31, 1'b0, 24'd5, 24'd1);

        // Random phases, each under its own enable mask; the last one runs flat out
        phase_mask[0] = 32'hFFFF_FFFF;
        phase_mask[1] = $urandom;
        phase_mask[2] = 32'h8000_0001;
        phase_mask[3] = $urandom;
        phase_mask[4] = 32'hFFFF_FFFF;
        for (int p = 0; p < NUM_PHASES; p++) begin
            write_enable_mask(phase_mask[p]);
            for (int k = 0; k < PHASE_BEATS; k++) begin
                send_random_beat();
                // Keep stretches of back-to-back beats between idle bursts
                allow_idle = (p != NUM_PHASES - 1) && ((k % 64) >= 16);
                if (allow_idle && $urandom_range(0, 3) == 0)
                    idle_for($urandom_range(1, 8));
                if (p == 1 && k == PHASE_BEATS / 2)
                    drain_results();
            end
        end

        drain_results();
        repeat (4) @(posedge i_clk);

        $display("covered %0d beats (%0d alarm requests) under %0d enable mask settings",
                 beats_sent, alarm_beats, mask_settings);
        $display("%0d result beats compared, %0d mismatches", results_checked, fail_count);
        if (fail_count == 0 && pending_results == 0) begin
            $display("timed_alarm_output_table_unit test passed");
        end else begin
            $display("timed_alarm_output_table_unit test failed");
        end
        $finish;
    end

endmodule
